[hdl/drm_pkg.sv]
// Shared types and codes for the dirty rectangle merge list.
// No dependencies; imported by the top level and its checker.
package drm_pkg;

  localparam int ScreenMax = 4096;

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NOP   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_APPENDED = 2'd0,
    STAT_MERGED   = 2'd1,
    STAT_DROPPED  = 2'd2,
    STAT_OVERFLOW = 2'd3
  } status_t;

  localparam logic [3:0] CFG_SCREEN_WIDTH  = 4'd0;
  localparam logic [3:0] CFG_SCREEN_HEIGHT = 4'd1;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] req_x;
    logic signed [15:0] req_y;
    logic signed [15:0] req_width;
    logic signed [15:0] req_height;
    logic [3:0]         read_index;
  } drm_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        entry_valid;
    logic [11:0] entry_x;
    logic [11:0] entry_y;
    logic [12:0] entry_width;
    logic [12:0] entry_height;
    logic [4:0]  list_length;
  } drm_out_t;

  // One stored rectangle, as held in the list memory.
  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [12:0] w;
    logic [12:0] h;
  } rect_t;

endpackage

[hdl/dirty_rect_merge_list_top.sv]
// Dirty rectangle merge list: list memory, scan sequencer and result register.
// Depends on drm_pkg.
//
// Usage: the renderer and the compositor issue beats on the in channel
// (valid/ready). kind selects add, read entry or clear; each accepted beat
// yields exactly one result beat on the out channel. Screen width and height
// are written over the cfg channel (index 0 width, index 1 height) while the
// block is idle; values above 4096 saturate.
// The list lives in a single-port-write, one-read synchronous memory. An add
// scans the stored entries twice through the read port, once to look for a
// full-screen entry and once to merge and compact; a full-screen entry ends
// the first pass early and drops the add. An add dropped at the screen edges,
// a clear or an unknown kind goes straight to the result; a read fetches its
// entry through S_RD and S_RDW first. One item is in flight at a time.
// Reset clears the entry count, the result valid flag and the sequencer, and
// loads the screen size with 480 by 320; the memory itself is not cleared.
// Stall: a result waits in the output register until taken; the sequencer
// holds its finished result and takes no new beat until the register frees.
module dirty_rect_merge_list_top
  import drm_pkg::*;
#(
  parameter int MAX_RECTS = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  drm_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output drm_out_t out_data,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  localparam int AW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int CW = $clog2(MAX_RECTS + 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_CHK  = 7'b0000010,
    S_CMP  = 7'b0000100,
    S_FIN  = 7'b0001000,
    S_RD   = 7'b0010000,
    S_RDW  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state;

  rect_t mem [MAX_RECTS];
  rect_t rdata;
  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  rect_t         wdata;

  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [CW-1:0] kept;
  logic [12:0]   sw;
  logic [12:0]   sh;
  logic [3:0]    rd_idx;
  logic          merged;
  drm_out_t      res;

  // clipped request and the growing merged area, as edges
  logic signed [18:0] rx, ry, rx1, ry1;
  logic signed [18:0] ax0, ay0, ax1, ay1;

  // request clipping at acceptance
  logic signed [17:0] qx, qy, qw, qh, cx, cy, cw, ch;
  logic signed [17:0] sw18, sh18;
  logic               early_drop;

  always_comb begin
    qx = {{2{in_data.req_x[15]}}, in_data.req_x};
    qy = {{2{in_data.req_y[15]}}, in_data.req_y};
    qw = {{2{in_data.req_width[15]}}, in_data.req_width};
    qh = {{2{in_data.req_height[15]}}, in_data.req_height};
    sw18 = {5'b0, sw};
    sh18 = {5'b0, sh};
    early_drop = 1'b0;
    if (qx < 0) begin
      cx = '0;
      cw = qw + qx;
    end else begin
      cx = qx;
      cw = qw;
      if (qx >= sw18) early_drop = 1'b1;
    end
    if (qy < 0) begin
      cy = '0;
      ch = qh + qy;
    end else begin
      cy = qy;
      ch = qh;
      if (qy >= sh18) early_drop = 1'b1;
    end
    if (cw <= 0 || ch <= 0) early_drop = 1'b1;
  end

  // stored entry seen by the scan, as edges
  logic signed [18:0] ex, ey, ex1, ey1, sw19, sh19;
  logic               full_screen, overlap;
  logic signed [18:0] aw, ah;

  always_comb begin
    ex   = {7'b0, rdata.x};
    ey   = {7'b0, rdata.y};
    ex1  = ex + {6'b0, rdata.w};
    ey1  = ey + {6'b0, rdata.h};
    sw19 = {6'b0, sw};
    sh19 = {6'b0, sh};
    full_screen = (rdata.x == '0) && (rdata.y == '0) && (rdata.w == sw) && (rdata.h == sh);
    // edges that only touch do not count
    overlap = (ex < rx1) && (rx < ex1) && (ey < ry1) && (ry < ey1);
    aw = (ax1 > sw19) ? (sw19 - ax0) : (ax1 - ax0);
    ah = (ay1 > sh19) ? (sh19 - ay0) : (ay1 - ay0);
  end

  logic slot_free;
  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // memory port control
  always_comb begin
    raddr = AW'(idx);
    we    = 1'b0;
    waddr = AW'(kept);
    wdata = rdata;
    case (state)
      S_RD: raddr = AW'(rd_idx);
      S_RDW: raddr = AW'(rd_idx);
      S_CMP: begin
        if (idx != '0 && !overlap) we = 1'b1;
      end
      S_FIN: begin
        we = 1'b1;
        if (kept >= CW'(MAX_RECTS)) begin
          waddr = '0;
          wdata = '{x: '0, y: '0, w: sw, h: sh};
        end else begin
          wdata = '{x: ax0[11:0], y: ay0[11:0], w: aw[12:0], h: ah[12:0]};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // configuration writes saturate at the largest screen size
  always_ff @(posedge clk) begin
    if (rst) begin
      sw <= 13'd480;
      sh <= 13'd320;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_SCREEN_WIDTH)
        sw <= (cfg_data > 13'(ScreenMax)) ? 13'(ScreenMax) : cfg_data;
      else if (cfg_index == CFG_SCREEN_HEIGHT)
        sh <= (cfg_data > 13'(ScreenMax)) ? 13'(ScreenMax) : cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // drop a taken beat unless a new one replaces it below
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            rd_idx <= in_data.read_index;
            idx    <= '0;
            kept   <= '0;
            merged <= 1'b0;
            rx     <= {1'b0, cx};
            ry     <= {1'b0, cy};
            rx1    <= {1'b0, cx} + {cw[17], cw};
            ry1    <= {1'b0, cy} + {ch[17], ch};
            ax0    <= {1'b0, cx};
            ay0    <= {1'b0, cy};
            ax1    <= {1'b0, cx} + {cw[17], cw};
            ay1    <= {1'b0, cy} + {ch[17], ch};
            case (in_data.kind)
              KIND_ADD: begin
                if (early_drop) begin
                  res   <= '{status: STAT_DROPPED, list_length: 5'(count), default: '0};
                  state <= S_DONE;
                end else begin
                  res   <= '0;
                  state <= S_CHK;
                end
              end
              KIND_READ: begin
                res   <= '0;
                state <= S_RD;
              end
              KIND_CLEAR: begin
                count <= '0;
                res   <= '0;
                state <= S_DONE;
              end
              default: begin
                res   <= '{list_length: 5'(count), default: '0};
                state <= S_DONE;
              end
            endcase
          end
        end
        // look for a full-screen entry before anything is changed
        S_CHK: begin
          if (idx != '0 && full_screen) begin
            res   <= '{status: STAT_DROPPED, list_length: 5'(count), default: '0};
            state <= S_DONE;
          end else if (idx == count) begin
            idx   <= '0;
            state <= S_CMP;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        // fold overlapping entries into the area, compact the rest
        S_CMP: begin
          if (idx != '0) begin
            if (overlap) begin
              merged <= 1'b1;
              if (ex < ax0) ax0 <= ex;
              if (ey < ay0) ay0 <= ey;
              if (ex1 > ax1) ax1 <= ex1;
              if (ey1 > ay1) ay1 <= ey1;
            end else begin
              kept <= kept + 1'b1;
            end
          end
          if (idx == count) state <= S_FIN;
          else idx <= idx + 1'b1;
        end
        S_FIN: begin
          if (kept >= CW'(MAX_RECTS)) begin
            count <= CW'(1);
            res   <= '{status: STAT_OVERFLOW, list_length: 5'd1, default: '0};
          end else begin
            count <= kept + 1'b1;
            res   <= '{status: merged ? STAT_MERGED : STAT_APPENDED,
                       list_length: 5'(kept + 1'b1), default: '0};
          end
          state <= S_DONE;
        end
        S_RD: state <= S_RDW;
        S_RDW: begin
          if (32'(rd_idx) < 32'(count)) begin
            res <= '{entry_valid: 1'b1, entry_x: rdata.x, entry_y: rdata.y,
                     entry_width: rdata.w, entry_height: rdata.h,
                     list_length: 5'(count), default: '0};
          end else begin
            res <= '{list_length: 5'(count), default: '0};
          end
          state <= S_DONE;
        end
        // hold the result until the output register frees
        S_DONE: begin
          if (slot_free) begin
            out_data  <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hdl/drm_checker.sv]
// Port-level checks for the dirty rectangle merge list, bound to the top level.
// Depends on drm_pkg and dirty_rect_merge_list_top.
module drm_checker
  import drm_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     out_valid,
  input logic     out_ready,
  input drm_out_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result beat right after reset");

  a_overflow: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == STAT_OVERFLOW |-> out_data.list_length == 5'd1)
    else $error("overflow did not collapse to one entry");

  a_read_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.entry_valid |->
      out_data.entry_x == '0 && out_data.entry_y == '0 &&
      out_data.entry_width == '0 && out_data.entry_height == '0)
    else $error("entry fields set without a valid entry");

endmodule

bind dirty_rect_merge_list_top drm_checker u_drm_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
